>>> sv/lifo_pkg.sv
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared types and constants of the LIFO stack block.
// ----------------------------------------------------------------------------
`default_nettype none

package lifo_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW         = $clog2(DEPTH + 1);

	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_POP  = 3'd1;
	localparam logic [2:0] MODE_REV  = 3'd2;
	localparam logic [2:0] MODE_SORT = 3'd3;
	localparam logic [2:0] MODE_SHOW = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_POP_RD,
		S_POP_OUT,
		S_REV_CHK,
		S_REV_WR_A,
		S_REV_WR_B,
		S_SORT_CHK,
		S_SORT_CMP,
		S_SORT_WR_B,
		S_SHOW_RD,
		S_SHOW_OUT,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		WR_PUSH,
		WR_A_FROM_B,
		WR_B_FROM_A
	} wr_sel_t;

	typedef struct packed {
		logic       start;
		logic       rd_en;
		logic       pair_next;
		logic       wr_en;
		wr_sel_t    wr_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       ia_inc;
		logic       ia_dec;
		logic       ia_clr;
		logic       ib_dec;
		logic       emit;
		logic [1:0] emit_status;
		logic       emit_data;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_zero;
		logic cnt_full;
		logic cnt_small;
		logic a_lt_b;
		logic ia_zero;
		logic ib_zero;
		logic row_end;
		logic swap;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/lifo_dp.sv
// ----------------------------------------------------------------------------
// lifo_dp
// Datapath: entry memory, fill count, index registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lifo_pkg::cmd_t                      cmd,
	input  wire logic [2:0]                          mode,
	input  wire logic [lifo_pkg::DATA_WIDTH-1:0]     push_value,
	output lifo_pkg::sts_t                           sts,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [lifo_pkg::DATA_WIDTH-1:0]          m_tdata,
	output logic [1:0]                               m_tuser,
	output logic                                     m_tlast
);

	logic [lifo_pkg::DATA_WIDTH-1:0] mem [lifo_pkg::DEPTH];

	logic [lifo_pkg::CW-1:0]         cnt_q;
	logic [lifo_pkg::CW-1:0]         cnt_m1;
	logic [lifo_pkg::AW-1:0]         ia_q;
	logic [lifo_pkg::AW-1:0]         ib_q;
	logic [lifo_pkg::AW-1:0]         addr_b;
	logic [lifo_pkg::AW-1:0]         wr_addr;
	logic [lifo_pkg::DATA_WIDTH-1:0] wr_data;
	logic [lifo_pkg::DATA_WIDTH-1:0] val_q;
	logic [lifo_pkg::DATA_WIDTH-1:0] rda_q;
	logic [lifo_pkg::DATA_WIDTH-1:0] rdb_q;
	logic                            out_valid_q;
	logic [lifo_pkg::DATA_WIDTH-1:0] out_data_q;
	logic [1:0]                      out_status_q;
	logic                            out_last_q;

	assign cnt_m1 = cnt_q - lifo_pkg::CW'(1);
	assign addr_b = cmd.pair_next ? (ia_q + lifo_pkg::AW'(1)) : ib_q;

	always_comb begin
		case (cmd.wr_sel)
			lifo_pkg::WR_PUSH: begin
				wr_addr = cnt_q[lifo_pkg::AW-1:0];
				wr_data = val_q;
			end
			lifo_pkg::WR_A_FROM_B: begin
				wr_addr = ia_q;
				wr_data = rdb_q;
			end
			default: begin
				wr_addr = addr_b;
				wr_data = rda_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rda_q <= mem[ia_q];
			rdb_q <= mem[addr_b];
		end
		if (cmd.start) begin
			val_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ia_q  <= '0;
			ib_q  <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + lifo_pkg::CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			// reverse and sort walk upward from the bottom, the rest start at the top
			if (cmd.start) begin
				ia_q <= (mode == lifo_pkg::MODE_REV || mode == lifo_pkg::MODE_SORT) ?
					'0 : cnt_m1[lifo_pkg::AW-1:0];
				ib_q <= cnt_m1[lifo_pkg::AW-1:0];
			end else begin
				if (cmd.ia_clr) begin
					ia_q <= '0;
				end else if (cmd.ia_inc) begin
					ia_q <= ia_q + lifo_pkg::AW'(1);
				end else if (cmd.ia_dec) begin
					ia_q <= ia_q - lifo_pkg::AW'(1);
				end
				if (cmd.ib_dec) begin
					ib_q <= ib_q - lifo_pkg::AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q   <= cmd.emit_data ? rda_q : '0;
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		sts.out_free  = !out_valid_q || m_tready;
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_full  = (cnt_q == lifo_pkg::CW'(lifo_pkg::DEPTH));
		sts.cnt_small = (cnt_q <= lifo_pkg::CW'(1));
		sts.a_lt_b    = (ia_q < ib_q);
		sts.ia_zero   = (ia_q == '0);
		sts.ib_zero   = (ib_q == '0);
		sts.row_end   = ((lifo_pkg::CW'(ia_q) + lifo_pkg::CW'(2)) == cnt_q);
		sts.swap      = ($signed(rda_q) < $signed(rdb_q));
	end

endmodule

`default_nettype wire

>>> sv/lifo_ctrl.sv
// ----------------------------------------------------------------------------
// lifo_ctrl
// Controller: sequences each operation over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic [2:0]     mode,
	output logic                s_tready,
	input  wire lifo_pkg::sts_t sts,
	output lifo_pkg::cmd_t      cmd
);

	lifo_pkg::state_t state_q;
	lifo_pkg::state_t state_d;
	logic             accept;

	assign s_tready = (state_q == lifo_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lifo_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lifo_pkg::S_IDLE: begin
				if (accept) begin
					unique case (mode)
						lifo_pkg::MODE_PUSH: state_d = lifo_pkg::S_PUSH;
						lifo_pkg::MODE_POP:  state_d = lifo_pkg::S_POP_RD;
						lifo_pkg::MODE_REV:  state_d = lifo_pkg::S_REV_CHK;
						lifo_pkg::MODE_SORT: state_d = lifo_pkg::S_SORT_CHK;
						lifo_pkg::MODE_SHOW: state_d = lifo_pkg::S_SHOW_RD;
						default:             state_d = lifo_pkg::S_IDLE;
					endcase
				end
			end
			lifo_pkg::S_PUSH: begin
				if (sts.out_free) state_d = lifo_pkg::S_IDLE;
			end
			lifo_pkg::S_POP_RD: begin
				if (!sts.cnt_zero) begin
					state_d = lifo_pkg::S_POP_OUT;
				end else if (sts.out_free) begin
					state_d = lifo_pkg::S_IDLE;
				end
			end
			lifo_pkg::S_POP_OUT: begin
				if (sts.out_free) state_d = lifo_pkg::S_IDLE;
			end
			lifo_pkg::S_REV_CHK: begin
				state_d = (!sts.cnt_small && sts.a_lt_b) ? lifo_pkg::S_REV_WR_A : lifo_pkg::S_FIN;
			end
			lifo_pkg::S_REV_WR_A: state_d = lifo_pkg::S_REV_WR_B;
			lifo_pkg::S_REV_WR_B: state_d = lifo_pkg::S_REV_CHK;
			lifo_pkg::S_SORT_CHK: begin
				state_d = (sts.cnt_small || sts.ib_zero) ? lifo_pkg::S_FIN : lifo_pkg::S_SORT_CMP;
			end
			lifo_pkg::S_SORT_CMP: begin
				state_d = sts.swap ? lifo_pkg::S_SORT_WR_B : lifo_pkg::S_SORT_CHK;
			end
			lifo_pkg::S_SORT_WR_B: state_d = lifo_pkg::S_SORT_CHK;
			lifo_pkg::S_SHOW_RD: begin
				if (!sts.cnt_zero) begin
					state_d = lifo_pkg::S_SHOW_OUT;
				end else if (sts.out_free) begin
					state_d = lifo_pkg::S_IDLE;
				end
			end
			lifo_pkg::S_SHOW_OUT: begin
				if (sts.out_free) begin
					state_d = sts.ia_zero ? lifo_pkg::S_IDLE : lifo_pkg::S_SHOW_RD;
				end
			end
			lifo_pkg::S_FIN: begin
				if (sts.out_free) state_d = lifo_pkg::S_IDLE;
			end
			default: state_d = lifo_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.wr_sel      = lifo_pkg::WR_PUSH;
		cmd.emit_status = lifo_pkg::ST_OK;
		cmd.start       = accept;
		unique case (state_q)
			lifo_pkg::S_IDLE: ;
			lifo_pkg::S_PUSH: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = sts.cnt_full ? lifo_pkg::ST_FULL : lifo_pkg::ST_OK;
					cmd.wr_en       = !sts.cnt_full;
					cmd.cnt_inc     = !sts.cnt_full;
				end
			end
			lifo_pkg::S_POP_RD: begin
				if (!sts.cnt_zero) begin
					cmd.rd_en = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = lifo_pkg::ST_EMPTY;
				end
			end
			lifo_pkg::S_POP_OUT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.cnt_dec   = 1'b1;
				end
			end
			lifo_pkg::S_REV_CHK: begin
				cmd.rd_en = !sts.cnt_small && sts.a_lt_b;
			end
			lifo_pkg::S_REV_WR_A: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lifo_pkg::WR_A_FROM_B;
			end
			lifo_pkg::S_REV_WR_B: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lifo_pkg::WR_B_FROM_A;
				cmd.ia_inc = 1'b1;
				cmd.ib_dec = 1'b1;
			end
			lifo_pkg::S_SORT_CHK: begin
				cmd.rd_en     = !(sts.cnt_small || sts.ib_zero);
				cmd.pair_next = 1'b1;
			end
			lifo_pkg::S_SORT_CMP: begin
				cmd.pair_next = 1'b1;
				if (sts.swap) begin
					// larger value sinks toward the bottom
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = lifo_pkg::WR_A_FROM_B;
				end else begin
					cmd.ia_clr = sts.row_end;
					cmd.ib_dec = sts.row_end;
					cmd.ia_inc = !sts.row_end;
				end
			end
			lifo_pkg::S_SORT_WR_B: begin
				cmd.pair_next = 1'b1;
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = lifo_pkg::WR_B_FROM_A;
				cmd.ia_clr    = sts.row_end;
				cmd.ib_dec    = sts.row_end;
				cmd.ia_inc    = !sts.row_end;
			end
			lifo_pkg::S_SHOW_RD: begin
				if (!sts.cnt_zero) begin
					cmd.rd_en = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = lifo_pkg::ST_EMPTY;
				end
			end
			lifo_pkg::S_SHOW_OUT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_data = 1'b1;
					cmd.emit_last = sts.ia_zero;
					cmd.ia_dec    = !sts.ia_zero;
				end
			end
			lifo_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/lifo_stack_sort_reverse.sv
// ----------------------------------------------------------------------------
// lifo_stack_sort_reverse
// Bounded stack of signed words with push, pop, reverse, sort and read-out.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group: s_tuser carries the operation code, s_tdata
// the value to push. Results leave on the m_ group: m_tuser is the status,
// m_tdata the popped or read-out value (zero otherwise), m_tlast marks the
// final result of a request. Codes 5 to 7 are taken and produce nothing.
// s_tready is high only while no operation is in progress; the block works
// on one request at a time, sequenced over a single-write, dual-read memory.
// For fill n: reverse swaps n/2 pairs, each read and then written to the
//   lower slot and the upper one; sort makes (n-1)*(n-1) compares of
//   neighbouring entries, and each swap writes the lower entry and then the
//   upper one. Pop and read-out read each entry before it is delivered.
//   s_tready returns once the last result has been registered.
// The result register decouples the sides: when m_tready is low the result
// holds and the sequencer stalls only at the next result it must deliver.
// Reset empties the stack at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_sort_reverse (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [lifo_pkg::DATA_WIDTH-1:0]     s_tdata,  // push_value
	input  wire logic [2:0]                          s_tuser,  // mode
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [lifo_pkg::DATA_WIDTH-1:0]          m_tdata,  // item_value
	output logic [1:0]                               m_tuser,  // status
	output logic                                     m_tlast
);

	lifo_pkg::cmd_t cmd;
	lifo_pkg::sts_t sts;

	lifo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lifo_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (s_tuser),
		.push_value (s_tdata),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// an accepted request with a code from push to read-out leaves s_tready low in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser <= lifo_pkg::MODE_SHOW) |=> !s_tready)
		else $error("accepted request did not occupy the sequencer");

	// never overwrite a result still waiting for the receiver
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result register overwritten while stalled");

	// a push writes the memory only when the stack is not full, and always raises the count with it
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_sel == lifo_pkg::WR_PUSH) |-> (!sts.cnt_full && cmd.cnt_inc))
		else $error("push written past capacity");

	// read-out and pop results that carry data come only while the stack holds entries
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_data) |-> !sts.cnt_zero)
		else $error("entry delivered from an empty stack");

endmodule

`default_nettype wire
